// File: sv/nmi_ovl_pkg.sv
// Package for the NMI overlay paging controller: request and response payload types,
// operation codes, device types, port bytes and register indexes.
// Depends on nothing; used by the core module.
`default_nettype none

package nmi_ovl_pkg;

   typedef enum logic [2:0] {
      OP_NMI_BUTTON = 3'd0,
      OP_FETCH_0066 = 3'd1,
      OP_RETN       = 3'd2,
      OP_PORT_READ  = 3'd3,
      OP_PORT_WRITE = 3'd4
   } op_type;

   localparam logic [1:0] DEV_PLUS3      = 2'd0;
   localparam logic [1:0] DEV_128_EARLY  = 2'd1;
   localparam logic [1:0] DEV_128_LATE   = 2'd2;
   localparam logic [1:0] DEV_48         = 2'd3;

   localparam logic [7:0] PORT_9F = 8'h9f;
   localparam logic [7:0] PORT_BF = 8'hbf;
   localparam logic [7:0] PORT_3F = 8'h3f;
   localparam logic [7:0] PORT_1F = 8'h1f;

   localparam logic [7:0] READBACK_FILL = 8'h7f;
   localparam logic [7:0] BUS_IDLE      = 8'hff;

   localparam logic [3:0] SEL_1FFD = 4'h1;
   localparam logic [3:0] SEL_7FFD = 4'h7;
   localparam logic [3:0] SEL_DFFD = 4'hd;
   localparam logic [3:0] SEL_EFF7 = 4'he;

   localparam int         CSR_INDEX_W = 1;
   localparam int         CSR_DATA_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_TYPE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ENABLE = 1'd1;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] port_address;
      logic [7:0]  page_reg_1ffd;
      logic [7:0]  page_reg_7ffd;
      logic [7:0]  page_reg_dffd;
      logic [7:0]  page_reg_eff7;
      logic [2:0]  border_colour;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       handled;
      logic       paged;
      logic       active;
      logic       nmi_hold;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/nmi_overlay_paging_controller_core.sv
// NMI overlay paging controller: flag state, port decode, readback and response buffering.
// Depends on nmi_ovl_pkg for the payload types and codes.
//
// Usage: each request on the req_ channel is one bus event (NMI button, fetch at 0x0066,
// RETN, port read or port write) together with the current paging register values.
// Every request yields exactly one response on the rsp_ channel carrying the read byte,
// whether the device drove the bus, and the paged, active and NMI-hold levels after
// the event has been applied.
// The response is registered and valid in the cycle after the request is taken, unless
// it waits in the skid register. One request per cycle is taken while req_stall is low;
// the flag update and decode are a single level of logic ahead of the response register.
// When the receiver stalls, the response register holds and one further response goes
// into a skid register; req_stall rises only while that skid register is full.
// The csr_ port writes device_type (index 0) and device_enable (index 1); the user must
// write them only when the block is idle, which the block itself does not enforce.
// Synchronous reset clears both output stages and sets type plus3, device enabled,
// NMI inactive, overlay unpaged and the control ports hidden.
`default_nettype none

module nmi_overlay_paging_controller_core (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  nmi_ovl_pkg::req_type            req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output nmi_ovl_pkg::rsp_type                  rsp_data,
   input  wire                                   csr_write,
   input  wire  [nmi_ovl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [nmi_ovl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import nmi_ovl_pkg::*;

   logic [1:0] device_type_ff;
   logic       device_enable_ff;
   logic       nmi_active_ff, nmi_active_in;
   logic       overlay_paged_ff, overlay_paged_in;
   logic       ports_hidden_ff, ports_hidden_in;
   logic       rsp_valid_ff, skid_valid_ff;
   rsp_type    rsp_data_ff, skid_data_ff;
   rsp_type    result_in;

   logic       accept, take_out;
   logic       p3, m48, hid;
   logic [7:0] en_port, dis_port, low, readback;
   logic       hit_en, hit_dis;

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take_out  = rsp_valid_ff && !rsp_stall;

   assign p3      = (device_type_ff == DEV_PLUS3);
   assign m48     = (device_type_ff == DEV_48);
   assign low     = req_data.port_address[7:0];
   assign hid     = ports_hidden_ff && !m48;

   always_comb begin
      case (device_type_ff)
         DEV_PLUS3: begin
            en_port  = PORT_3F;
            dis_port = PORT_BF;
         end
         DEV_128_EARLY: begin
            en_port  = PORT_BF;
            dis_port = PORT_3F;
         end
         default: begin
            en_port  = PORT_9F;
            dis_port = PORT_1F;
         end
      endcase
   end

   assign hit_en  = (low == en_port);
   assign hit_dis = !hit_en && (low == dis_port);

   always_comb begin
      if (p3) begin
         case (req_data.port_address[15:12])
            SEL_1FFD: readback = req_data.page_reg_1ffd;
            SEL_7FFD: readback = req_data.page_reg_7ffd;
            SEL_DFFD: readback = req_data.page_reg_dffd;
            SEL_EFF7: readback = req_data.page_reg_eff7;
            default:  readback = {5'd0, req_data.border_colour};
         endcase
      end else begin
         readback = {req_data.page_reg_7ffd[3], 7'd0} | READBACK_FILL;
      end
   end

   always_comb begin
      nmi_active_in       = nmi_active_ff;
      overlay_paged_in    = overlay_paged_ff;
      ports_hidden_in     = ports_hidden_ff;
      result_in.read_data = BUS_IDLE;
      result_in.handled   = 1'b0;
      case (req_data.operation)
         OP_NMI_BUTTON: begin
            if (device_enable_ff && !nmi_active_ff) begin
               nmi_active_in   = 1'b1;
               ports_hidden_in = 1'b0;
            end
         end
         OP_FETCH_0066: begin
            if (device_enable_ff && nmi_active_ff) begin
               overlay_paged_in = 1'b1;
            end
         end
         OP_RETN: begin
            nmi_active_in    = 1'b0;
            overlay_paged_in = 1'b0;
         end
         OP_PORT_READ: begin
            if (device_enable_ff && hit_en) begin
               overlay_paged_in = !hid;
               if (!hid && !m48) begin
                  result_in.handled   = 1'b1;
                  result_in.read_data = readback;
               end
            end else if (device_enable_ff && hit_dis) begin
               overlay_paged_in = 1'b0;
               if (p3) begin
                  nmi_active_in = 1'b0;
               end
            end
         end
         OP_PORT_WRITE: begin
            if (device_enable_ff && hit_en) begin
               nmi_active_in = 1'b0;
               if (p3) begin
                  ports_hidden_in = 1'b1;
               end
            end else if (device_enable_ff && hit_dis) begin
               nmi_active_in = 1'b0;
               if (!p3) begin
                  ports_hidden_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      result_in.paged    = device_enable_ff && overlay_paged_in;
      result_in.active   = device_enable_ff && (overlay_paged_in || nmi_active_in);
      result_in.nmi_hold = device_enable_ff && nmi_active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_type_ff   <= DEV_PLUS3;
         device_enable_ff <= 1'b1;
         nmi_active_ff    <= 1'b0;
         overlay_paged_ff <= 1'b0;
         ports_hidden_ff  <= 1'b1;
      end else begin
         if (csr_write && csr_index == CSR_DEVICE_TYPE) begin
            device_type_ff <= csr_wdata[1:0];
         end
         if (csr_write && csr_index == CSR_DEVICE_ENABLE) begin
            device_enable_ff <= csr_wdata[0];
         end
         if (accept) begin
            nmi_active_ff    <= nmi_active_in;
            overlay_paged_ff <= overlay_paged_in;
            ports_hidden_ff  <= ports_hidden_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take_out) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take_out) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take_out) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take_out) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take_out) begin
            rsp_data_ff <= result_in;
         end else begin
            skid_data_ff <= result_in;
         end
      end
   end

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a response while the output register is empty");

   a_idle_bus: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.handled) |-> (rsp_data_ff.read_data == BUS_IDLE))
      else $error("undriven response does not read as idle bus");

   a_hold_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.nmi_hold) |-> rsp_data_ff.active)
      else $error("NMI hold reported without active");

   a_retn_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation == OP_RETN) |=> (!nmi_active_ff && !overlay_paged_ff))
      else $error("RETN did not clear NMI and overlay flags");
`endif

endmodule

`default_nettype wire

// File: sim/nmi_ovl_checker.sv
// Response checker for the NMI overlay paging controller: tracks the flags and registers,
// predicts one response per request and compares responses in order.
// Depends on nmi_ovl_pkg for the payload types, opcodes, port bytes and register indexes.
`default_nettype none

module nmi_ovl_checker (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   input  wire                                   req_stall,
   input  wire  nmi_ovl_pkg::req_type            req_data,
   input  wire                                   rsp_valid,
   input  wire                                   rsp_stall,
   input  wire  nmi_ovl_pkg::rsp_type            rsp_data,
   input  wire                                   csr_write,
   input  wire  [nmi_ovl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [nmi_ovl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                    mismatch_count,
   output int                                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import nmi_ovl_pkg::*;

   logic [1:0] dev_type;
   logic       dev_on;
   logic       nmi_serving;
   logic       overlay_in;
   logic       ports_masked;
   rsp_type    expected_q[$];

   function automatic rsp_type predict_event(input req_type r);
      rsp_type    res;
      logic [7:0] on_port;
      logic [7:0] off_port;
      logic [7:0] low;
      logic       plus3;
      logic       m48;
      logic       masked;
      res.read_data = BUS_IDLE;
      res.handled = 1'b0;
      plus3 = dev_type == DEV_PLUS3;
      m48 = dev_type == DEV_48;
      on_port = plus3 ? PORT_3F : (dev_type == DEV_128_EARLY) ? PORT_BF : PORT_9F;
      off_port = plus3 ? PORT_BF : (dev_type == DEV_128_EARLY) ? PORT_3F : PORT_1F;
      low = r.port_address[7:0];
      case (r.operation)
         OP_NMI_BUTTON: if (dev_on && !nmi_serving) begin
            nmi_serving = 1'b1;
            ports_masked = 1'b0;
         end
         OP_FETCH_0066: if (dev_on && nmi_serving) begin
            overlay_in = 1'b1;
         end
         OP_RETN: begin
            nmi_serving = 1'b0;
            overlay_in = 1'b0;
         end
         OP_PORT_READ: if (dev_on) begin
            if (low == on_port) begin
               masked = ports_masked && !m48;
               overlay_in = !masked;
               if (!masked && !m48) begin
                  res.handled = 1'b1;
                  if (plus3) begin
                     case (r.port_address[15:12])
                        SEL_1FFD: res.read_data = r.page_reg_1ffd;
                        SEL_7FFD: res.read_data = r.page_reg_7ffd;
                        SEL_DFFD: res.read_data = r.page_reg_dffd;
                        SEL_EFF7: res.read_data = r.page_reg_eff7;
                        default:  res.read_data = {5'b00000, r.border_colour};
                     endcase
                  end else begin
                     res.read_data = READBACK_FILL | {r.page_reg_7ffd[3], 7'b0000000};
                  end
               end
            end else if (low == off_port) begin
               overlay_in = 1'b0;
               if (plus3) begin
                  nmi_serving = 1'b0;
               end
            end
         end
         OP_PORT_WRITE: if (dev_on) begin
            if (low == on_port) begin
               nmi_serving = 1'b0;
               if (plus3) begin
                  ports_masked = 1'b1;
               end
            end else if (low == off_port) begin
               nmi_serving = 1'b0;
               if (!plus3) begin
                  ports_masked = 1'b1;
               end
            end
         end
         default: ;
      endcase
      res.paged = dev_on && overlay_in;
      res.active = dev_on && (overlay_in || nmi_serving);
      res.nmi_hold = dev_on && nmi_serving;
      return res;
   endfunction

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (reset) begin
         dev_type = DEV_PLUS3;
         dev_on = 1'b1;
         nmi_serving = 1'b0;
         overlay_in = 1'b0;
         ports_masked = 1'b1;
         expected_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DEVICE_TYPE:   dev_type = csr_wdata[1:0];
               CSR_DEVICE_ENABLE: dev_on = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) begin
                  $display("%0t: response with no request outstanding: data %02h handled %0b",
                           $realtime, rsp_data.read_data, rsp_data.handled);
               end
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.read_data !== want.read_data || rsp_data.handled !== want.handled
                   || rsp_data.paged !== want.paged || rsp_data.active !== want.active
                   || rsp_data.nmi_hold !== want.nmi_hold) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10) begin
                     $display("%0t: expected data %02h handled %0b paged %0b active %0b hold %0b",
                              $realtime, want.read_data, want.handled, want.paged,
                              want.active, want.nmi_hold);
                     $display("%0t:      got data %02h handled %0b paged %0b active %0b hold %0b",
                              $realtime, rsp_data.read_data, rsp_data.handled,
                              rsp_data.paged, rsp_data.active, rsp_data.nmi_hold);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_q.push_back(predict_event(req_data));
         end
      end
      pending_count <= expected_q.size();
   end

endmodule

`default_nettype wire

// File: sim/nmi_overlay_paging_controller_core_tb.sv
// Testbench top for the NMI overlay paging controller: clock, reset, request stimulus,
// response stalls, register writes, watchdog and verdict.
// Depends on nmi_ovl_pkg, the core module and the nmi_ovl_checker module.
`default_nettype none

module nmi_overlay_paging_controller_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nmi_ovl_pkg::*;

   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;
   localparam int PHASE_REQUESTS = 183;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     mismatches;
   int                     pending;
   int                     requests_sent = 0;
   int                     quiet_cycles = 0;
   int                     stall_left = 0;
   int                     stall_draw;
   bit                     burst = 1'b0;

   nmi_overlay_paging_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nmi_ovl_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = burst ? 0 : $urandom_range(0, 9);
         stall_left <= stall_draw;
         rsp_stall <= (stall_draw != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type bus_event(input logic [2:0] op, input logic [15:0] addr,
                                         input bit fixed, input logic [7:0] fill);
      req_type r;
      r.operation = op;
      r.port_address = addr;
      r.page_reg_1ffd = fixed ? fill : 8'($urandom_range(0, 255));
      r.page_reg_7ffd = fixed ? fill : 8'($urandom_range(0, 255));
      r.page_reg_dffd = fixed ? fill : 8'($urandom_range(0, 255));
      r.page_reg_eff7 = fixed ? fill : 8'($urandom_range(0, 255));
      r.border_colour = fixed ? fill[2:0] : 3'($urandom_range(0, 7));
      return r;
   endfunction

   function automatic logic [15:0] random_port();
      logic [7:0] high;
      logic [7:0] low;
      high = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
         0:       low = PORT_9F;
         1:       low = PORT_BF;
         2:       low = PORT_3F;
         3:       low = PORT_1F;
         default: low = 8'($urandom_range(0, 255));
      endcase
      return {high, low};
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      requests_sent = requests_sent + 1;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic run_phase(input logic [1:0] dev, input logic enable);
      logic    spare;
      logic [2:0] op;
      int      target;
      int      n;
      drain();
      spare = 1'($urandom_range(0, 1));
      csr_write <= 1'b1;
      csr_index <= CSR_DEVICE_TYPE;
      csr_wdata <= dev;
      @(posedge clock);
      csr_index <= CSR_DEVICE_ENABLE;
      csr_wdata <= {spare, enable};
      @(posedge clock);
      csr_write <= 1'b0;
      target = requests_sent + PHASE_REQUESTS;
      while (requests_sent < target) begin
         burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) begin
            send_request(bus_event(OP_NMI_BUTTON, random_port(), 1'b0, 8'h00));
            if ($urandom_range(0, 5) != 0) begin
               send_request(bus_event(OP_FETCH_0066, random_port(), 1'b0, 8'h00));
            end
            n = $urandom_range(1, 6);
            repeat (n) begin
               op = $urandom_range(0, 1) ? OP_PORT_READ : OP_PORT_WRITE;
               send_request(bus_event(op, random_port(), 1'b0, 8'h00));
            end
            if ($urandom_range(0, 3) != 0) begin
               send_request(bus_event(OP_RETN, random_port(), 1'b0, 8'h00));
            end
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               op = 3'($urandom_range(0, 7));
               send_request(bus_event(op, 16'($urandom_range(0, 65535)), 1'b0, 8'h00));
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(bus_event(OP_PORT_READ, 16'h003f, 1'b0, 8'h00));
      send_request(bus_event(OP_PORT_WRITE, 16'hffbf, 1'b0, 8'h00));
      send_request(bus_event(OP_NMI_BUTTON, 16'h0000, 1'b0, 8'h00));
      send_request(bus_event(OP_NMI_BUTTON, 16'h0000, 1'b0, 8'h00));
      send_request(bus_event(OP_FETCH_0066, 16'h0066, 1'b0, 8'h00));
      send_request(bus_event(OP_PORT_READ, 16'h1f3f, 1'b1, 8'h00));
      send_request(bus_event(OP_PORT_READ, 16'h7f3f, 1'b1, 8'hff));
      send_request(bus_event(OP_PORT_READ, 16'hdf3f, 1'b0, 8'h00));
      send_request(bus_event(OP_PORT_READ, 16'hef3f, 1'b0, 8'h00));
      send_request(bus_event(OP_PORT_READ, 16'h0f3f, 1'b0, 8'h00));
      send_request(bus_event(OP_PORT_READ, 16'hff3f, 1'b1, 8'hff));
      send_request(bus_event(OP_PORT_READ, 16'h0000, 1'b1, 8'h00));
      send_request(bus_event(OP_PORT_READ, 16'hffff, 1'b1, 8'hff));
      send_request(bus_event(OP_UNUSED_LO, 16'h003f, 1'b0, 8'h00));
      send_request(bus_event(OP_UNUSED_HI, 16'h00bf, 1'b0, 8'h00));
      send_request(bus_event(OP_PORT_READ, 16'h00bf, 1'b0, 8'h00));
      send_request(bus_event(OP_NMI_BUTTON, 16'hffff, 1'b0, 8'h00));
      send_request(bus_event(OP_PORT_WRITE, 16'h003f, 1'b0, 8'h00));
      send_request(bus_event(OP_PORT_READ, 16'h003f, 1'b0, 8'h00));
      send_request(bus_event(OP_NMI_BUTTON, 16'h0000, 1'b0, 8'h00));
      send_request(bus_event(OP_FETCH_0066, 16'h0066, 1'b0, 8'h00));
      send_request(bus_event(OP_RETN, 16'h0000, 1'b0, 8'h00));
      send_request(bus_event(OP_FETCH_0066, 16'h0066, 1'b0, 8'h00));
      send_request(bus_event(OP_PORT_WRITE, 16'h0000, 1'b0, 8'h00));

      run_phase(DEV_PLUS3, 1'b1);
      run_phase(DEV_128_EARLY, 1'b1);
      run_phase(DEV_128_LATE, 1'b1);
      run_phase(DEV_48, 1'b1);
      run_phase(DEV_48, 1'b0);
      run_phase(DEV_128_LATE, 1'b1);
      run_phase(DEV_128_EARLY, 1'b0);
      run_phase(DEV_PLUS3, 1'b0);
      run_phase(DEV_PLUS3, 1'b1);
      run_phase(DEV_48, 1'b1);

      drain();
      if (mismatches == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
sv/nmi_ovl_pkg.sv
sv/nmi_overlay_paging_controller_core.sv
sim/nmi_ovl_checker.sv
sim/nmi_overlay_paging_controller_core_tb.sv
